// File: hdl/utf16_to_utf8_transcoder_core_macros.svh
// assertion helpers shared by the transcoder modules
`ifndef UTF16_TO_UTF8_TRANSCODER_CORE_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define U16U8_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("u16u8 same-cycle check failed");

// next-cycle implication, checked outside reset
`define U16U8_ASSERT_NXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("u16u8 next-cycle check failed");

`endif

// File: hdl/u16u8_pkg.sv
package u16u8_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
   localparam logic [15:0] SURR_HIGH_TOP  = 16'hDBFF;
   localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
   localparam logic [15:0] SURR_LOW_TOP   = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE      = 21'h10000;

   localparam logic [7:0] LEAD2_MARK = 8'hC0;
   localparam logic [7:0] LEAD3_MARK = 8'hE0;
   localparam logic [7:0] LEAD4_MARK = 8'hF0;
   localparam logic [7:0] CONT_MARK  = 8'h80;

   // up to two code points to encode back to back
   typedef struct packed {
      logic [20:0] cp0;
      logic        has1;
      logic [15:0] cp1;
   } cmd_type;

   // number of utf-8 bytes for a code point
   function automatic logic [2:0] utf8_len(input logic [20:0] cp);
      logic [2:0] len;
      begin
         if (cp < 21'h80) len = 3'd1;
         else if (cp < 21'h800) len = 3'd2;
         else if (cp < 21'h10000) len = 3'd3;
         else len = 3'd4;
         return len;
      end
   endfunction

   // byte idx of the utf-8 form of a code point
   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
      logic [7:0] res;
      begin
         res = 8'h00;
         case (utf8_len(cp))
            3'd1: res = {1'b0, cp[6:0]};
            3'd2: res = (idx == 2'd0) ? (LEAD2_MARK | {3'b000, cp[10:6]})
                                      : (CONT_MARK | {2'b00, cp[5:0]});
            3'd3: begin
               case (idx)
                  2'd0: res = LEAD3_MARK | {4'b0000, cp[15:12]};
                  2'd1: res = CONT_MARK | {2'b00, cp[11:6]};
                  default: res = CONT_MARK | {2'b00, cp[5:0]};
               endcase
            end
            default: begin
               case (idx)
                  2'd0: res = LEAD4_MARK | {5'b00000, cp[20:18]};
                  2'd1: res = CONT_MARK | {2'b00, cp[17:12]};
                  2'd2: res = CONT_MARK | {2'b00, cp[11:6]};
                  default: res = CONT_MARK | {2'b00, cp[5:0]};
               endcase
            end
         endcase
         return res;
      end
   endfunction

endpackage

// File: hdl/u16u8_req_if.sv
interface u16u8_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

// File: hdl/u16u8_rsp_if.sv
interface u16u8_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;

   modport source (output valid, output out_byte, output run_last, input ready);
   modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

// File: hdl/u16u8_front.sv
module u16u8_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_write_data,
   u16u8_req_if.sink          req_chan,
   input  logic               queue_full,
   output logic               push,
   output u16u8_pkg::cmd_type push_cmd
);

   logic       big_endian_ff, big_endian_in;
   logic [7:0] first_half_ff, first_half_in;
   logic       have_first_ff, have_first_in;
   logic [9:0] held_ff, held_in;
   logic       have_held_ff, have_held_in;

   logic        accept;
   logic [15:0] unit;
   logic        unit_high;
   logic        unit_low;

   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && req_chan.ready;

   assign unit = big_endian_ff ? {first_half_ff, req_chan.in_byte}
                               : {req_chan.in_byte, first_half_ff};

   always_comb begin
      unit_high = unit inside {[u16u8_pkg::SURR_HIGH_BASE:u16u8_pkg::SURR_HIGH_TOP]};
      unit_low  = unit inside {[u16u8_pkg::SURR_LOW_BASE:u16u8_pkg::SURR_LOW_TOP]};
   end

   always_comb begin
      big_endian_in = csr_write_enable ? csr_write_data : big_endian_ff;
      first_half_in = first_half_ff;
      have_first_in = have_first_ff;
      held_in       = held_ff;
      have_held_in  = have_held_ff;
      push          = 1'b0;
      push_cmd      = '0;
      if (accept) begin
         if (!have_first_ff) begin
            first_half_in = req_chan.in_byte;
            have_first_in = 1'b1;
            // odd trailing byte: dropped, a held surrogate goes out alone
            if (req_chan.last_byte && have_held_ff) begin
               push = 1'b1;
               push_cmd.cp0 = {5'b00000, u16u8_pkg::SURR_HIGH_BASE | {6'b000000, held_ff}};
            end
         end else begin
            have_first_in = 1'b0;
            if (have_held_ff) begin
               have_held_in = 1'b0;
               push = 1'b1;
               if (unit_low) begin
                  push_cmd.cp0 = u16u8_pkg::SUPP_BASE + {1'b0, held_ff, unit[9:0]};
               end else begin
                  push_cmd.cp0 = {5'b00000, u16u8_pkg::SURR_HIGH_BASE | {6'b000000, held_ff}};
                  if (unit_high && !req_chan.last_byte) begin
                     held_in      = unit[9:0];
                     have_held_in = 1'b1;
                  end else begin
                     push_cmd.has1 = 1'b1;
                     push_cmd.cp1  = unit;
                  end
               end
            end else if (unit_high && !req_chan.last_byte) begin
               held_in      = unit[9:0];
               have_held_in = 1'b1;
            end else begin
               push = 1'b1;
               push_cmd.cp0 = {5'b00000, unit};
            end
         end
         if (req_chan.last_byte) begin
            first_half_in = 8'h00;
            have_first_in = 1'b0;
            held_in       = 10'h000;
            have_held_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b1;
         first_half_ff <= 8'h00;
         have_first_ff <= 1'b0;
         held_ff       <= 10'h000;
         have_held_ff  <= 1'b0;
      end else begin
         big_endian_ff <= big_endian_in;
         first_half_ff <= first_half_in;
         have_first_ff <= have_first_in;
         held_ff       <= held_in;
         have_held_ff  <= have_held_in;
      end
   end

endmodule

// File: hdl/u16u8_queue.sv
`include "utf16_to_utf8_transcoder_core_macros.svh"

module u16u8_queue #(
   parameter int Depth = u16u8_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u16u8_pkg::cmd_type push_cmd,
   output logic               full,
   input  logic               pop,
   output u16u8_pkg::cmd_type pop_cmd,
   output logic               empty
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   u16u8_pkg::cmd_type    slot_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign full    = (count_ff == CountWidth'(Depth));
   assign empty   = (count_ff == '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

   `U16U8_ASSERT_IMP(a_no_push_full, clock, reset, push, !full)
   `U16U8_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, !empty)
   `U16U8_ASSERT_NXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

// File: hdl/u16u8_back.sv
`include "utf16_to_utf8_transcoder_core_macros.svh"

module u16u8_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_empty,
   input  u16u8_pkg::cmd_type queue_cmd,
   output logic               pop,
   u16u8_rsp_if.source        rsp_chan
);

   u16u8_pkg::cmd_type cur_ff, cur_in;
   logic               cur_valid_ff, cur_valid_in;
   logic               sel_ff, sel_in;
   logic [1:0]         idx_ff, idx_in;

   logic [20:0] cur_cp;
   logic [2:0]  cur_len;
   logic        elem_last;
   logic        cmd_last;
   logic        fire;
   logic        reload;

   assign cur_cp    = sel_ff ? {5'b00000, cur_ff.cp1} : cur_ff.cp0;
   assign cur_len   = u16u8_pkg::utf8_len(cur_cp);
   assign elem_last = ({1'b0, idx_ff} == (cur_len - 3'd1));
   assign cmd_last  = elem_last && (sel_ff || !cur_ff.has1);
   assign fire      = cur_valid_ff && rsp_chan.ready;
   assign reload    = !cur_valid_ff || (fire && cmd_last);
   assign pop       = reload && !queue_empty;

   assign rsp_chan.valid    = cur_valid_ff;
   assign rsp_chan.out_byte = u16u8_pkg::utf8_byte(cur_cp, idx_ff);
   assign rsp_chan.run_last = cmd_last;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      sel_in       = sel_ff;
      idx_in       = idx_ff;
      if (reload) begin
         cur_in       = queue_cmd;
         cur_valid_in = !queue_empty;
         sel_in       = 1'b0;
         idx_in       = 2'd0;
      end else if (fire) begin
         if (elem_last) begin
            sel_in = 1'b1;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         sel_ff       <= sel_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   `U16U8_ASSERT_IMP(a_idx_in_range, clock, reset, cur_valid_ff, {1'b0, idx_ff} < cur_len)
   `U16U8_ASSERT_IMP(a_sel_needs_second, clock, reset, cur_valid_ff && sel_ff, cur_ff.has1)
   `U16U8_ASSERT_NXT(a_stall_holds, clock, reset, cur_valid_ff && !rsp_chan.ready, cur_valid_ff && $stable(idx_ff) && $stable(sel_ff))

endmodule

// File: hdl/utf16_to_utf8_transcoder_core.sv
// channel     direction  transaction contents
// req_chan    in         in_byte (utf-16 byte), last_byte (end of string)
// rsp_chan    out        out_byte (utf-8 byte), run_last (last byte from one input)
// csr         in         csr_write_enable, csr_write_data (big_endian, reset 1)
//
// an input byte is taken whenever the command queue has room
// the back end sends one utf-8 byte per cycle while rsp_chan is ready, so a code
// point is 1 to 4 bytes and a broken surrogate pair up to 6 bytes at the output
// reset is synchronous, active high; it empties the queue and resets all control state
// either side may stall on its own, the queue absorbs up to QueueDepth commands
module utf16_to_utf8_transcoder_core #(
   parameter int QueueDepth = u16u8_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   u16u8_req_if.sink   req_chan,
   u16u8_rsp_if.source rsp_chan
);

   // commands from the classifier to the encoder
   u16u8_pkg::cmd_type push_cmd;
   u16u8_pkg::cmd_type pop_cmd;
   logic               push;
   logic               pop;
   logic               queue_full;
   logic               queue_empty;

   // front: byte pairing, surrogate holding, byte order register
   u16u8_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .queue_full       (queue_full),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   // short command queue decoupling the two halves
   u16u8_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (queue_empty)
   );

   // back: walks the utf-8 bytes of each command, one per cycle while rsp_chan is ready
   u16u8_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_cmd   (pop_cmd),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule
